// File: design/alru_pkg.sv
// ----------------------------------------------------------------------------
// alru_pkg
// Shared types and constants of the LRU block cache directory.
// ----------------------------------------------------------------------------
package alru_pkg;

   localparam int NODE_W    = 64;
   localparam int BLOCK_W   = 64;
   localparam int TAG_W     = NODE_W + BLOCK_W;
   localparam int AGE_W     = 32;
   localparam int STAT_W    = 32;
   localparam int CFG_W     = 5;
   localparam int LINE_OUT_W = 4;
   localparam int COUNT_OUT_W = 5;
   localparam logic [CFG_W-1:0] LINES_IN_USE_RESET = 5'd16;

   // Operation codes
   typedef enum logic [0:0] {
      CMD_GET = 1'b0,
      CMD_PUT = 1'b1
   } cmd_type;

   // Control of the scan unit from the sequencer
   typedef struct packed {
      logic clear;   // start of a new item: drop all accumulated results
      logic beat;    // one line's tag, age and valid bit are presented
   } scan_ctl_type;

   // Saturating increment of a line age
   function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] age);
      age_inc = (age == {AGE_W{1'b1}}) ? age : age + {{(AGE_W-1){1'b0}}, 1'b1};
   endfunction

endpackage

// File: design/alru_ram.sv
// ----------------------------------------------------------------------------
// alru_ram
// Simple dual-port memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module alru_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// File: design/alru_scan.sv
// ----------------------------------------------------------------------------
// alru_scan
// Shared compare unit: takes one line per beat and keeps the first matching
// line, the first free line, the oldest line and the number of valid lines.
// ----------------------------------------------------------------------------
module alru_scan #(
   parameter int LINES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  alru_pkg::scan_ctl_type            ctl,
   input  logic [((LINES > 1) ? $clog2(LINES) : 1)-1:0] beat_idx,
   input  logic                              beat_line_valid,
   input  logic [alru_pkg::TAG_W-1:0]        key,
   input  logic [alru_pkg::TAG_W-1:0]        beat_tag,
   input  logic [alru_pkg::AGE_W-1:0]        beat_age,
   output logic                              match_found,
   output logic [((LINES > 1) ? $clog2(LINES) : 1)-1:0] match_idx,
   output logic                              free_found,
   output logic [((LINES > 1) ? $clog2(LINES) : 1)-1:0] free_idx,
   output logic [((LINES > 1) ? $clog2(LINES) : 1)-1:0] old_idx,
   output logic [$clog2(LINES + 1)-1:0]      valid_cnt
);

   localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int CNT_W = $clog2(LINES + 1);

   logic                       match_found_ff, match_found_in;
   logic [IDX_W-1:0]           match_idx_ff, match_idx_in;
   logic                       free_found_ff, free_found_in;
   logic [IDX_W-1:0]           free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]           old_idx_ff, old_idx_in;
   logic [alru_pkg::AGE_W-1:0] old_age_ff, old_age_in;
   logic [CNT_W-1:0]           valid_cnt_ff, valid_cnt_in;
   logic                       tag_eq;

   assign tag_eq = (beat_tag == key);

   // Accumulate over beats; only valid lines can match
   always_comb begin
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      old_idx_in     = old_idx_ff;
      old_age_in     = old_age_ff;
      valid_cnt_in   = valid_cnt_ff;
      if (ctl.clear) begin
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
         valid_cnt_in   = '0;
      end else if (ctl.beat) begin
         if (beat_line_valid && tag_eq && !match_found_ff) begin
            match_found_in = 1'b1;
            match_idx_in   = beat_idx;
         end
         if (!beat_line_valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = beat_idx;
         end
         // strictly older wins, so ties keep the lowest index
         if (beat_idx == '0 || beat_age > old_age_ff) begin
            old_idx_in = beat_idx;
            old_age_in = beat_age;
         end
         if (beat_line_valid) begin
            valid_cnt_in = valid_cnt_ff + {{(CNT_W-1){1'b0}}, 1'b1};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         valid_cnt_ff   <= '0;
      end else begin
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         valid_cnt_ff   <= valid_cnt_in;
      end
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      old_idx_ff   <= old_idx_in;
      old_age_ff   <= old_age_in;
   end

   assign match_found = match_found_ff;
   assign match_idx   = match_idx_ff;
   assign free_found  = free_found_ff;
   assign free_idx    = free_idx_ff;
   assign old_idx     = old_idx_ff;
   assign valid_cnt   = valid_cnt_ff;

endmodule

// File: design/assoc_lru_block_cache_directory.sv
// ----------------------------------------------------------------------------
// assoc_lru_block_cache_directory
// Flow: a put or a get miss scans the n enabled lines once, then decides and
// responds; a get hit adds a second pass rewriting every enabled line's age.
// A new item is accepted only in idle, after the last response is registered;
// the line scan reads the tag and age memories one line per cycle.
// Reset: synchronous; clears valid bits, counters and lines_in_use to 16.
// No clearing pass: ages and tags are always written before being used.
// ----------------------------------------------------------------------------
module assoc_lru_block_cache_directory #(
   parameter int LINES = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [63:0] req_node_id,
   input  logic [63:0] req_block_id,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_hit,
   output logic [3:0]  rsp_line_index,
   output logic        rsp_evicted,
   output logic [4:0]  rsp_item_count,
   output logic [31:0] rsp_query_count,
   output logic [31:0] rsp_hit_count,
   // configuration
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata
);

   localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int CNT_W = $clog2(LINES + 1);
   localparam int AGE_W = alru_pkg::AGE_W;
   localparam int TAG_W = alru_pkg::TAG_W;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_TOUCH  = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type                    state_ff, state_in;
   logic [alru_pkg::CFG_W-1:0]   lines_in_use_ff, lines_in_use_in;
   logic                         cmd_ff, cmd_in;
   logic [TAG_W-1:0]             key_ff, key_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         pv_ff, pv_in;
   logic [IDX_W-1:0]             pidx_ff, pidx_in;
   logic [IDX_W-1:0]             line_ff, line_in;
   logic                         hit_ff, hit_in;
   logic                         evict_ff, evict_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [alru_pkg::STAT_W-1:0]  queries_ff, queries_in;
   logic [alru_pkg::STAT_W-1:0]  hits_ff, hits_in;
   logic [LINES-1:0]             valid_ff, valid_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_hit_ff, rsp_hit_in;
   logic [3:0]                   rsp_line_ff, rsp_line_in;
   logic                         rsp_evicted_ff, rsp_evicted_in;
   logic [4:0]                   rsp_count_ff, rsp_count_in;
   logic [31:0]                  rsp_query_ff, rsp_query_in;
   logic [31:0]                  rsp_hits_ff, rsp_hits_in;

   logic [31:0]          liu_wide;
   logic [31:0]          n_wide;
   logic [CNT_W-1:0]     n_lines;
   logic                 req_fire;
   logic                 rd_issue;
   logic [IDX_W-1:0]     rd_addr;
   logic                 tag_wr_en;
   logic [IDX_W-1:0]     tag_wr_addr;
   logic [TAG_W-1:0]     tag_rd;
   logic                 age_wr_en;
   logic [IDX_W-1:0]     age_wr_addr;
   logic [AGE_W-1:0]     age_wr_data;
   logic [AGE_W-1:0]     age_rd;
   logic                 is_put;
   logic [IDX_W-1:0]     line_sel;
   logic [31:0]          line_wide;
   logic [31:0]          count_wide;

   alru_pkg::scan_ctl_type scan_ctl;
   logic                   sc_match_found;
   logic [IDX_W-1:0]       sc_match_idx;
   logic                   sc_free_found;
   logic [IDX_W-1:0]       sc_free_idx;
   logic [IDX_W-1:0]       sc_old_idx;
   logic [CNT_W-1:0]       sc_valid_cnt;

   // Enabled lines: zero acts as one, above LINES acts as LINES
   always_comb begin
      liu_wide = {27'b0, lines_in_use_ff};
      if (liu_wide == 32'd0) begin
         n_wide = 32'd1;
      end else if (liu_wide > 32'(LINES)) begin
         n_wide = 32'(LINES);
      end else begin
         n_wide = liu_wide;
      end
      n_lines = n_wide[CNT_W-1:0];
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign is_put    = (cmd_ff == alru_pkg::CMD_PUT);

   // Line read pipeline for both passes
   assign rd_issue = ((state_ff == ST_SCAN) || (state_ff == ST_TOUCH)) && (cnt_ff < n_lines);
   assign rd_addr  = cnt_ff[IDX_W-1:0];

   assign scan_ctl.clear = req_fire;
   assign scan_ctl.beat  = (state_ff == ST_SCAN) && pv_ff;

   // Line chosen at the decide step
   always_comb begin
      if (sc_match_found) begin
         line_sel = sc_match_idx;
      end else if (!is_put) begin
         line_sel = '0;
      end else if (sc_free_found) begin
         line_sel = sc_free_idx;
      end else begin
         line_sel = sc_old_idx;
      end
   end

   // Tag and age write ports
   always_comb begin
      tag_wr_en   = (state_ff == ST_DECIDE) && is_put && !sc_match_found;
      tag_wr_addr = line_sel;
      age_wr_en   = 1'b0;
      age_wr_addr = pidx_ff;
      age_wr_data = alru_pkg::age_inc(age_rd);
      unique case (state_ff)
         ST_SCAN: begin
            // a put always touches, so everyone ages during the scan
            age_wr_en = pv_ff && is_put;
         end
         ST_DECIDE: begin
            age_wr_en   = is_put;
            age_wr_addr = line_sel;
            age_wr_data = {{(AGE_W-1){1'b0}}, 1'b1};
         end
         ST_TOUCH: begin
            age_wr_en = pv_ff;
            if (pidx_ff == line_ff) begin
               age_wr_data = {{(AGE_W-1){1'b0}}, 1'b1};
            end
         end
         default: begin
            age_wr_en = 1'b0;
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in        = state_ff;
      lines_in_use_in = lines_in_use_ff;
      cmd_in          = cmd_ff;
      key_in          = key_ff;
      cnt_in          = cnt_ff;
      pv_in           = 1'b0;
      pidx_in         = pidx_ff;
      line_in         = line_ff;
      hit_in          = hit_ff;
      evict_in        = evict_ff;
      count_in        = count_ff;
      queries_in      = queries_ff;
      hits_in         = hits_ff;
      valid_in        = valid_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_hit_in      = rsp_hit_ff;
      rsp_line_in     = rsp_line_ff;
      rsp_evicted_in  = rsp_evicted_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_query_in    = rsp_query_ff;
      rsp_hits_in     = rsp_hits_ff;
      line_wide       = 32'(line_ff);
      count_wide      = 32'(count_ff);

      if (csr_we) begin
         lines_in_use_in = csr_wdata;
      end

      if (rd_issue) begin
         pv_in   = 1'b1;
         pidx_in = rd_addr;
         cnt_in  = cnt_ff + {{(CNT_W-1){1'b0}}, 1'b1};
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in   = req_cmd;
               key_in   = {req_node_id, req_block_id};
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == n_lines && !pv_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            line_in  = line_sel;
            hit_in   = sc_match_found;
            evict_in = is_put && !sc_match_found && !sc_free_found;
            count_in = sc_valid_cnt;
            if (is_put && !sc_match_found) begin
               valid_in[line_sel] = 1'b1;
               if (sc_free_found) begin
                  count_in = sc_valid_cnt + {{(CNT_W-1){1'b0}}, 1'b1};
               end
            end
            if (!is_put) begin
               if (queries_ff != {alru_pkg::STAT_W{1'b1}}) begin
                  queries_in = queries_ff + 32'd1;
               end
               if (sc_match_found && hits_ff != {alru_pkg::STAT_W{1'b1}}) begin
                  hits_in = hits_ff + 32'd1;
               end
            end
            cnt_in = '0;
            if (!is_put && sc_match_found) begin
               state_in = ST_TOUCH;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_TOUCH: begin
            if (cnt_ff == n_lines && !pv_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_hit_in     = hit_ff;
               rsp_line_in    = line_wide[3:0];
               rsp_evicted_in = evict_ff;
               rsp_count_in   = (count_wide > 32'd31) ? 5'd31 : count_wide[4:0];
               rsp_query_in   = queries_ff;
               rsp_hits_in    = hits_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         lines_in_use_ff <= alru_pkg::LINES_IN_USE_RESET;
         pv_ff           <= 1'b0;
         cnt_ff          <= '0;
         queries_ff      <= '0;
         hits_ff         <= '0;
         valid_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         lines_in_use_ff <= lines_in_use_in;
         pv_ff           <= pv_in;
         cnt_ff          <= cnt_in;
         queries_ff      <= queries_in;
         hits_ff         <= hits_in;
         valid_ff        <= valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      key_ff         <= key_in;
      pidx_ff        <= pidx_in;
      line_ff        <= line_in;
      hit_ff         <= hit_in;
      evict_ff       <= evict_in;
      count_ff       <= count_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_line_ff    <= rsp_line_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_query_ff   <= rsp_query_in;
      rsp_hits_ff    <= rsp_hits_in;
   end

   // Tag store: node and block identifiers side by side
   alru_ram #(
      .WIDTH (TAG_W),
      .DEPTH (LINES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_wr_en),
      .wr_addr (tag_wr_addr),
      .wr_data (key_ff),
      .rd_en   (rd_issue && (state_ff == ST_SCAN)),
      .rd_addr (rd_addr),
      .rd_data (tag_rd)
   );

   // Age store
   alru_ram #(
      .WIDTH (AGE_W),
      .DEPTH (LINES)
   ) u_age_ram (
      .clock   (clock),
      .wr_en   (age_wr_en),
      .wr_addr (age_wr_addr),
      .wr_data (age_wr_data),
      .rd_en   (rd_issue),
      .rd_addr (rd_addr),
      .rd_data (age_rd)
   );

   // Shared compare unit
   alru_scan #(
      .LINES (LINES)
   ) u_scan (
      .clock           (clock),
      .reset           (reset),
      .ctl             (scan_ctl),
      .beat_idx        (pidx_ff),
      .beat_line_valid (valid_ff[pidx_ff]),
      .key             (key_ff),
      .beat_tag        (tag_rd),
      .beat_age        (age_rd),
      .match_found     (sc_match_found),
      .match_idx       (sc_match_idx),
      .free_found      (sc_free_found),
      .free_idx        (sc_free_idx),
      .old_idx         (sc_old_idx),
      .valid_cnt       (sc_valid_cnt)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_line_index  = rsp_line_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_item_count  = rsp_count_ff;
   assign rsp_query_count = rsp_query_ff;
   assign rsp_hit_count   = rsp_hits_ff;

endmodule

// File: tb/sv/tb_assoc_lru_block_cache_directory.sv
// ----------------------------------------------------------------------------
// tb_assoc_lru_block_cache_directory
// Self-checking bench for the LRU block cache directory. Requests go in over
// a valid/ready channel with random gaps. A cycle-free model of the
// directory predicts each response beat, and every beat is checked field by
// field against that prediction. Directed tests cover tag extremes, LRU age
// ties and the lines_in_use limits. Random traffic then runs over several
// line counts, and one test holds the response side off for a long stretch.
// ----------------------------------------------------------------------------
module tb_assoc_lru_block_cache_directory;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIR_LINES     = 16;
   localparam int SETTLE_CYCLES = 2 * DIR_LINES + 8;
   localparam int LIMIT_CYCLES  = 1000000;
   localparam int POOL_MAX      = 32;

   typedef struct packed {
      logic                             hit;
      logic [alru_pkg::LINE_OUT_W-1:0]  line_index;
      logic                             evicted;
      logic [alru_pkg::COUNT_OUT_W-1:0] item_count;
      logic [alru_pkg::STAT_W-1:0]      query_count;
      logic [alru_pkg::STAT_W-1:0]      hit_count;
   } lookup_result_type;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic                             req_cmd;
   logic [alru_pkg::NODE_W-1:0]      req_node_id;
   logic [alru_pkg::BLOCK_W-1:0]     req_block_id;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic                             rsp_hit;
   logic [alru_pkg::LINE_OUT_W-1:0]  rsp_line_index;
   logic                             rsp_evicted;
   logic [alru_pkg::COUNT_OUT_W-1:0] rsp_item_count;
   logic [alru_pkg::STAT_W-1:0]      rsp_query_count;
   logic [alru_pkg::STAT_W-1:0]      rsp_hit_count;
   logic                             csr_we;
   logic [alru_pkg::CFG_W-1:0]       csr_wdata;

   // Directory model state
   logic                         dir_valid     [DIR_LINES];
   logic [alru_pkg::NODE_W-1:0]  dir_node_tag  [DIR_LINES];
   logic [alru_pkg::BLOCK_W-1:0] dir_block_tag [DIR_LINES];
   logic [alru_pkg::AGE_W-1:0]   dir_age       [DIR_LINES];
   logic [alru_pkg::STAT_W-1:0]  gets_seen;
   logic [alru_pkg::STAT_W-1:0]  get_hits;
   logic [alru_pkg::CFG_W-1:0]   lines_cfg;

   lookup_result_type      pending_lookups [$];

   int                     error_count;
   int                     cycle_count;
   int                     requests_sent;
   int                     puts_sent;
   int                     evictions_seen;
   int                     cfg_writes;
   int                     rsp_hold_cycles;
   bit                     quiet_mode;

   assoc_lru_block_cache_directory #(.LINES(DIR_LINES)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_node_id     (req_node_id),
      .req_block_id    (req_block_id),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_line_index  (rsp_line_index),
      .rsp_evicted     (rsp_evicted),
      .rsp_item_count  (rsp_item_count),
      .rsp_query_count (rsp_query_count),
      .rsp_hit_count   (rsp_hit_count),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAIL assoc_lru_block_cache_directory");
         $finish;
      end
   end

   // Gap length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      else if (roll < 85)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // ---------------------------------------------------------------------
   // Directory model
   // ---------------------------------------------------------------------
   function automatic void clear_directory();
      for (int i = 0; i < DIR_LINES; i++) begin
         dir_valid[i]     = 1'b0;
         dir_node_tag[i]  = '0;
         dir_block_tag[i] = '0;
         dir_age[i]       = '0;
      end
      gets_seen = '0;
      get_hits  = '0;
      lines_cfg = alru_pkg::LINES_IN_USE_RESET;
   endfunction

   // zero behaves as one, anything over the line count is clamped
   function automatic int enabled_lines();
      if (lines_cfg == 0)
         return 1;
      if (lines_cfg > DIR_LINES)
         return DIR_LINES;
      return int'(lines_cfg);
   endfunction

   // touched line restarts at zero, then every enabled line ages (saturating)
   function automatic void touch_line(input int line, input int n);
      dir_age[line] = '0;
      for (int i = 0; i < n; i++)
         if (dir_age[i] != {alru_pkg::AGE_W{1'b1}})
            dir_age[i] = dir_age[i] + 1'b1;
   endfunction

   function automatic lookup_result_type predict_lookup(input alru_pkg::cmd_type cmd,
         input logic [alru_pkg::NODE_W-1:0] node,
         input logic [alru_pkg::BLOCK_W-1:0] block);
      lookup_result_type res;
      int n, line, cnt;
      bit found, evict, free_found;
      n = enabled_lines();
      line = 0;
      cnt = 0;
      found = 1'b0;
      evict = 1'b0;
      free_found = 1'b0;

      // first valid enabled line with both tags equal
      for (int i = 0; i < n; i++)
         if (!found && dir_valid[i] && dir_node_tag[i] == node &&
             dir_block_tag[i] == block) begin
            found = 1'b1;
            line = i;
         end

      if (cmd == alru_pkg::CMD_GET) begin
         if (gets_seen != {alru_pkg::STAT_W{1'b1}})
            gets_seen = gets_seen + 1'b1;
         if (found) begin
            if (get_hits != {alru_pkg::STAT_W{1'b1}})
               get_hits = get_hits + 1'b1;
            touch_line(line, n);
         end
      end else if (found) begin
         touch_line(line, n);
      end else begin
         // lowest free line, else the oldest (lowest index on a tie)
         for (int i = 0; i < n; i++)
            if (!free_found && !dir_valid[i]) begin
               free_found = 1'b1;
               line = i;
            end
         if (!free_found) begin
            line = 0;
            for (int i = 1; i < n; i++)
               if (dir_age[i] > dir_age[line])
                  line = i;
            evict = 1'b1;
            evictions_seen++;
         end
         dir_valid[line]     = 1'b1;
         dir_node_tag[line]  = node;
         dir_block_tag[line] = block;
         touch_line(line, n);
      end

      for (int i = 0; i < n; i++)
         if (dir_valid[i])
            cnt++;
      if (cnt > 31)
         cnt = 31;

      res.hit         = found;
      res.line_index  = line[alru_pkg::LINE_OUT_W-1:0];
      res.evicted     = evict;
      res.item_count  = cnt[alru_pkg::COUNT_OUT_W-1:0];
      res.query_count = gets_seen;
      res.hit_count   = get_hits;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Response side: ready with random stalls, plus a long hold on request
   // ---------------------------------------------------------------------
   initial begin : rsp_side
      int unsigned stall;
      forever begin
         if (rsp_hold_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = quiet_mode ? 0 : pick_gap();
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // Check each response beat against the oldest prediction
   always @(posedge clock) begin : check_rsp
      lookup_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_lookups.size() == 0) begin
            $error("response beat with no request outstanding");
            error_count++;
         end else begin
            want = pending_lookups.pop_front();
            compare_field("hit",         64'(want.hit),         64'(rsp_hit));
            compare_field("line_index",  64'(want.line_index),  64'(rsp_line_index));
            compare_field("evicted",     64'(want.evicted),     64'(rsp_evicted));
            compare_field("item_count",  64'(want.item_count),  64'(rsp_item_count));
            compare_field("query_count", 64'(want.query_count), 64'(rsp_query_count));
            compare_field("hit_count",   64'(want.hit_count),   64'(rsp_hit_count));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   task automatic send_request(input alru_pkg::cmd_type cmd,
                               input logic [alru_pkg::NODE_W-1:0] node,
                               input logic [alru_pkg::BLOCK_W-1:0] block);
      int unsigned gap;
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_node_id  <= node;
      req_block_id <= block;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      // beat taken at this edge
      pending_lookups.push_back(predict_lookup(cmd, node, block));
      requests_sent++;
      if (cmd == alru_pkg::CMD_PUT)
         puts_sent++;
      gap = quiet_mode ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering, wait for every response, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_lookups.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only called with the block idle
   task automatic set_lines_in_use(input logic [alru_pkg::CFG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      lines_cfg = value;
      cfg_writes++;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Empty-cache miss, fills, hits, update and near-miss keys at tag extremes
   task automatic test_basic_lookup();
      send_request(alru_pkg::CMD_GET, '0, '0);
      send_request(alru_pkg::CMD_PUT, '0, '0);
      send_request(alru_pkg::CMD_PUT, '1, '1);
      send_request(alru_pkg::CMD_GET, '0, '0);
      send_request(alru_pkg::CMD_GET, '1, '1);
      send_request(alru_pkg::CMD_PUT, '1, '1);
      send_request(alru_pkg::CMD_GET, '1, '0);
      send_request(alru_pkg::CMD_GET, '0, '1);
      send_request(alru_pkg::CMD_PUT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
   endtask

   // Eviction by age, then an age tie made by disabling and re-enabling a line
   task automatic test_lru_ties();
      logic [alru_pkg::NODE_W-1:0]  a_node, d_node;
      logic [alru_pkg::BLOCK_W-1:0] a_block, d_block;
      a_node  = random_word();
      a_block = random_word();
      d_node  = random_word();
      d_block = random_word();
      wait_idle();
      set_lines_in_use(5'd2);
      send_request(alru_pkg::CMD_PUT, a_node, a_block);
      send_request(alru_pkg::CMD_PUT, random_word(), random_word());
      send_request(alru_pkg::CMD_GET, a_node, a_block);
      send_request(alru_pkg::CMD_PUT, random_word(), random_word());
      // line 1 youngest, so it freezes at the same age line 0 will reach
      send_request(alru_pkg::CMD_GET, dir_node_tag[1], dir_block_tag[1]);
      wait_idle();
      set_lines_in_use(5'd1);
      send_request(alru_pkg::CMD_PUT, d_node, d_block);
      wait_idle();
      set_lines_in_use(5'd2);
      send_request(alru_pkg::CMD_PUT, random_word(), random_word());
      send_request(alru_pkg::CMD_GET, d_node, d_block);
   endtask

   // lines_in_use of zero acts as one; values above the line count clamp
   task automatic test_line_count_limits();
      logic [alru_pkg::NODE_W-1:0]  f_node, g_node, h_node;
      logic [alru_pkg::BLOCK_W-1:0] f_block, g_block, h_block;
      f_node  = random_word();
      f_block = random_word();
      g_node  = random_word();
      g_block = random_word();
      h_node  = random_word();
      h_block = random_word();
      wait_idle();
      set_lines_in_use(5'd0);
      send_request(alru_pkg::CMD_PUT, f_node, f_block);
      send_request(alru_pkg::CMD_GET, f_node, f_block);
      send_request(alru_pkg::CMD_PUT, g_node, g_block);
      send_request(alru_pkg::CMD_GET, f_node, f_block);
      wait_idle();
      set_lines_in_use(5'd31);
      send_request(alru_pkg::CMD_PUT, h_node, h_block);
      send_request(alru_pkg::CMD_GET, g_node, g_block);
      wait_idle();
      set_lines_in_use(5'd17);
      send_request(alru_pkg::CMD_GET, h_node, h_block);
   endtask

   // Random gets and puts over a key pool a little larger than the enabled lines
   task automatic run_traffic_phase(input logic [alru_pkg::CFG_W-1:0] lines_value,
                                    input int items, input bit quiet);
      logic [alru_pkg::NODE_W-1:0]  pool_node  [POOL_MAX];
      logic [alru_pkg::BLOCK_W-1:0] pool_block [POOL_MAX];
      int pool_size, pick, roll;
      alru_pkg::cmd_type cmd;
      wait_idle();
      set_lines_in_use(lines_value);
      quiet_mode = quiet;
      pool_size = enabled_lines() + $urandom_range(1, enabled_lines() / 2 + 2);
      // some keys share one half with an earlier key
      for (int k = 0; k < pool_size; k++) begin
         pool_node[k]  = (k != 0 && $urandom_range(0, 99) < 20) ?
                         pool_node[$urandom_range(0, k - 1)] : random_word();
         pool_block[k] = (k != 0 && $urandom_range(0, 99) < 20) ?
                         pool_block[$urandom_range(0, k - 1)] : random_word();
      end
      for (int j = 0; j < items; j++) begin
         cmd  = ($urandom_range(0, 99) < 45) ? alru_pkg::CMD_PUT : alru_pkg::CMD_GET;
         pick = $urandom_range(0, pool_size - 1);
         roll = $urandom_range(0, 99);
         if (roll < 82)
            send_request(cmd, pool_node[pick], pool_block[pick]);
         else if (roll < 92)
            send_request(cmd, pool_node[pick], random_word());
         else
            send_request(cmd, random_word(), random_word());
      end
      quiet_mode = 1'b0;
   endtask

   task automatic test_random_traffic();
      logic [alru_pkg::CFG_W-1:0] settings [10];
      settings = '{5'd16, 5'd1, 5'd0, 5'd5, 5'd31, 5'd2, 5'd12, 5'd17, 5'd3, 5'd16};
      for (int p = 0; p < 10; p++)
         run_traffic_phase(settings[p], 155, (p % 3) == 1);
   endtask

   // Response side held off while requests keep coming, then a full drain
   task automatic test_output_backpressure();
      logic [alru_pkg::NODE_W-1:0]  node_keys  [20];
      logic [alru_pkg::BLOCK_W-1:0] block_keys [20];
      int pick;
      wait_idle();
      set_lines_in_use(5'd16);
      for (int k = 0; k < 20; k++) begin
         node_keys[k]  = random_word();
         block_keys[k] = random_word();
      end
      rsp_hold_cycles = 400;
      for (int j = 0; j < 40; j++) begin
         pick = $urandom_range(0, 19);
         send_request(($urandom_range(0, 1) != 0) ? alru_pkg::CMD_PUT : alru_pkg::CMD_GET,
                      node_keys[pick], block_keys[pick]);
      end
      wait_idle();
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_cmd      <= alru_pkg::CMD_GET;
      req_node_id  <= '0;
      req_block_id <= '0;
      csr_we       <= 1'b0;
      csr_wdata    <= '0;
      requests_sent  = 0;
      puts_sent      = 0;
      evictions_seen = 0;
      cfg_writes     = 0;
      rsp_hold_cycles = 0;
      quiet_mode     = 1'b0;
      clear_directory();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_lookup();
      test_lru_ties();
      test_line_count_limits();
      test_random_traffic();
      test_output_backpressure();
      wait_idle();

      $display("Run covered %0d requests (%0d puts, %0d gets with %0d hits, %0d evictions)",
               requests_sent, puts_sent, gets_seen, get_hits, evictions_seen);
      $display("over %0d lines_in_use writes, with random stalls and one long response hold",
               cfg_writes);
      if (error_count == 0 && pending_lookups.size() == 0)
         $display("PASS assoc_lru_block_cache_directory");
      else
         $display("FAIL assoc_lru_block_cache_directory");
      $finish;
   end

endmodule

// File: filelist.f
design/alru_pkg.sv
design/alru_ram.sv
design/alru_scan.sv
design/assoc_lru_block_cache_directory.sv
tb/sv/tb_assoc_lru_block_cache_directory.sv
